/* hw/rtl/ifcf_pkg.sv */
// ----------------------------------------------------------------------------
// ifcf_pkg
// shared types, widths and arithmetic helpers of the integrate-and-fire
// token framer
// ----------------------------------------------------------------------------
package ifcf_pkg;

    // vector geometry
    localparam int VECTOR_LEN = 512;
    localparam int IDX_W      = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int FILL_W     = $clog2(VECTOR_LEN + 1);

    // field widths
    localparam int W_W    = 17;   // weight, Q1.16
    localparam int VAL_W  = 24;   // hidden value, Q8.16
    localparam int THR_W  = 18;   // threshold, Q2.16
    localparam int WIN_W  = 8;    // frame window bounds and frame position
    localparam int FAC_W  = THR_W + 1;
    localparam int PROD_W = FAC_W + VAL_W;
    localparam int RND_W  = PROD_W - 15;
    localparam int ACC_W  = 26;   // accumulator, Q10.16
    localparam int SUM_W  = RND_W + 1;

    // reset values of the registers
    localparam logic [THR_W-1:0] THR_RESET       = THR_W'(65536);
    localparam logic [WIN_W-1:0] WIN_FIRST_RESET = WIN_W'(5);
    localparam logic [WIN_W-1:0] WIN_END_RESET   = WIN_W'(15);

    localparam logic [WIN_W-1:0] FPOS_MAX = '1;
    localparam logic [W_W-1:0]   INTEGRAL_MAX = '1;

    // apb register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIN_FIRST = 2'd1;
    localparam logic [1:0] REG_WIN_END   = 2'd2;

    // saturation bounds
    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'((2 ** (ACC_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_LO = SUM_W'(-(2 ** (ACC_W - 1)));
    localparam logic signed [SUM_W-1:0] OUT_HI = SUM_W'((2 ** (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] OUT_LO = SUM_W'(-(2 ** (VAL_W - 1)));

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [WIN_W-1:0] win_first;
        logic [WIN_W-1:0] win_end;
    } t_cfg;

    // one element after the firing decision
    typedef struct packed {
        logic                    fire;
        logic                    last;
        logic [IDX_W-1:0]        idx;
        logic signed [FAC_W-1:0] factor;  // weight, or threshold minus integral
        logic signed [FAC_W-1:0] resid;   // integral plus weight minus threshold
        logic signed [VAL_W-1:0] value;
    } t_issue;

    // Q11.32 to Q12.16, nearest with ties toward plus infinity
    function automatic logic signed [RND_W-1:0] round_q16(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [PROD_W:0] y;
        y = {x[PROD_W-1], x} + (PROD_W + 1)'(32768);
        return y[PROD_W:16];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] y;
        y = x;
        if (x > ACC_HI) begin
            y = ACC_HI;
        end else if (x < ACC_LO) begin
            y = ACC_LO;
        end
        return y[ACC_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] y;
        y = x;
        if (x > OUT_HI) begin
            y = OUT_HI;
        end else if (x < OUT_LO) begin
            y = OUT_LO;
        end
        return y[VAL_W-1:0];
    endfunction

endpackage

/* hw/rtl/ifcf_front.sv */
// ----------------------------------------------------------------------------
// ifcf_front
// position tracking, frame window, integral and firing decision per element
// ----------------------------------------------------------------------------
module ifcf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [ifcf_pkg::W_W-1:0]        i_weight,
    input  logic signed [ifcf_pkg::VAL_W-1:0] i_value,
    input  logic                            i_frame_last,
    input  logic                            i_chunk_first,
    input  ifcf_pkg::t_cfg                  i_cfg,
    output ifcf_pkg::t_issue                o_issue
);

    logic [ifcf_pkg::W_W-1:0]   r_integral, n_integral;
    logic [ifcf_pkg::WIN_W-1:0] r_fpos, n_fpos;
    logic [ifcf_pkg::IDX_W-1:0] r_epos, n_epos;

    logic [ifcf_pkg::WIN_W-1:0] fpos;
    logic [ifcf_pkg::IDX_W-1:0] epos;
    logic                       in_win;
    logic [ifcf_pkg::W_W-1:0]   w_eff;
    logic [ifcf_pkg::THR_W-1:0] sum;
    logic [ifcf_pkg::THR_W-1:0] resid;
    logic [ifcf_pkg::THR_W-1:0] next_int;
    logic                       fire;

    always_comb begin
        fpos   = i_chunk_first ? '0 : r_fpos;
        epos   = i_chunk_first ? '0 : r_epos;
        in_win = (fpos >= i_cfg.win_first) && (fpos < i_cfg.win_end);
        w_eff  = in_win ? i_weight : '0;
        sum    = {1'b0, r_integral} + {1'b0, w_eff};
        fire   = sum >= i_cfg.threshold;
        resid  = sum - i_cfg.threshold;
        next_int = fire ? resid : sum;

        o_issue.fire   = fire;
        o_issue.last   = i_frame_last;
        o_issue.idx    = epos;
        o_issue.factor = fire ? ($signed({1'b0, i_cfg.threshold})
                                 - $signed({2'b00, r_integral}))
                              : $signed({2'b00, w_eff});
        o_issue.resid  = $signed({1'b0, resid});
        o_issue.value  = i_value;

        // integral moves only at the end of a frame
        n_integral = r_integral;
        n_fpos     = fpos;
        if (i_frame_last) begin
            n_integral = (next_int > {1'b0, ifcf_pkg::INTEGRAL_MAX})
                       ? ifcf_pkg::INTEGRAL_MAX : next_int[ifcf_pkg::W_W-1:0];
            n_fpos     = (fpos == ifcf_pkg::FPOS_MAX) ? fpos : fpos + 1'b1;
            n_epos     = '0;
        end else if ((ifcf_pkg::IDX_W + 1)'(epos) + 1'b1
                     == (ifcf_pkg::IDX_W + 1)'(ifcf_pkg::VECTOR_LEN)) begin
            n_epos = '0;
        end else begin
            n_epos = ifcf_pkg::IDX_W'((ifcf_pkg::IDX_W + 1)'(epos) + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_fpos     <= '0;
            r_epos     <= '0;
        end else if (i_accept) begin
            r_integral <= n_integral;
            r_fpos     <= n_fpos;
            r_epos     <= n_epos;
        end
    end

endmodule

/* hw/rtl/integrate_and_fire_token_framer.sv */
// ----------------------------------------------------------------------------
// integrate_and_fire_token_framer
// continuous integrate-and-fire over streamed encoder elements, emits tokens
// ----------------------------------------------------------------------------
// One hidden element is accepted per clock cycle unless the input is held off.
// An element is decided (window, integral, fire or integrate) in the cycle it
// is accepted, its accumulator entry is read from a 512 x 26 single-write,
// single-read memory at the same edge, and stage 1 then multiplies, rounds,
// saturates and writes the entry back when it retires. A fired element passes
// from stage 1 into the output register. The input is held off only while a
// firing element waits behind a full, unread output register. The accumulator
// needs no clearing pass after reset: entries are always written as a prefix
// from position 0, so a fill count marks which entries still read as zero.
// Consecutive accesses to one entry are forwarded around the memory.
// Registers on APB: 0x0 fire threshold (Q2.16), 0x4 window first, 0x8 window
// end; they are meant to be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module integrate_and_fire_token_framer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // element stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [47:0]                       i_s_tdata,  // weight[16:0], value[40:17], zero pad
    input  logic                              i_s_tlast,  // frame_last
    input  logic                              i_s_tuser,  // chunk_first
    // token stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ifcf_pkg::VAL_W-1:0]        o_m_tdata,  // token_value[23:0]
    output logic                              o_m_tlast,  // token_last
    // configuration
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [ifcf_pkg::PADDR_W-1:0]      i_paddr,
    input  logic [ifcf_pkg::PDATA_W-1:0]      i_pwdata,
    output logic [ifcf_pkg::PDATA_W-1:0]      o_prdata,
    output logic                              o_pready
);

    // configuration registers
    ifcf_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           cfg_wr;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[ifcf_pkg::PADDR_W-1:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= ifcf_pkg::THR_RESET;
            r_cfg.win_first <= ifcf_pkg::WIN_FIRST_RESET;
            r_cfg.win_end   <= ifcf_pkg::WIN_END_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                ifcf_pkg::REG_THRESHOLD: r_cfg.threshold <= i_pwdata[ifcf_pkg::THR_W-1:0];
                ifcf_pkg::REG_WIN_FIRST: r_cfg.win_first <= i_pwdata[ifcf_pkg::WIN_W-1:0];
                ifcf_pkg::REG_WIN_END:   r_cfg.win_end   <= i_pwdata[ifcf_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ifcf_pkg::REG_THRESHOLD: o_prdata = ifcf_pkg::PDATA_W'(r_cfg.threshold);
            ifcf_pkg::REG_WIN_FIRST: o_prdata = ifcf_pkg::PDATA_W'(r_cfg.win_first);
            ifcf_pkg::REG_WIN_END:   o_prdata = ifcf_pkg::PDATA_W'(r_cfg.win_end);
            default:                 o_prdata = '0;
        endcase
    end

    // handshake and pipeline control
    logic             s_accept;
    logic             s1_adv;
    ifcf_pkg::t_issue issue;

    ifcf_pkg::t_issue r_s1;
    logic             r_s1_valid, n_s1_valid;
    logic             r_o_valid, n_o_valid;

    // a non-firing element always leaves stage 1, a firing one needs room
    assign s1_adv     = r_s1_valid && (!r_s1.fire || !r_o_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;

    ifcf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_weight      (i_s_tdata[ifcf_pkg::W_W-1:0]),
        .i_value       ($signed(i_s_tdata[ifcf_pkg::W_W +: ifcf_pkg::VAL_W])),
        .i_frame_last  (i_s_tlast),
        .i_chunk_first (i_s_tuser),
        .i_cfg         (r_cfg),
        .o_issue       (issue)
    );

    // accumulator memory, read at accept, written back when stage 1 retires
    logic signed [ifcf_pkg::ACC_W-1:0] mem_acc [ifcf_pkg::VECTOR_LEN];
    logic signed [ifcf_pkg::ACC_W-1:0] r_rd;
    logic signed [ifcf_pkg::ACC_W-1:0] r_byp_data;
    logic                              r_byp_hit;
    logic                              r_fresh;
    logic [ifcf_pkg::FILL_W-1:0]       r_fill, n_fill;

    logic signed [ifcf_pkg::ACC_W-1:0]  acc_old;
    logic signed [ifcf_pkg::PROD_W-1:0] p_main;
    logic signed [ifcf_pkg::PROD_W-1:0] p_res;
    logic signed [ifcf_pkg::RND_W-1:0]  rnd_main;
    logic signed [ifcf_pkg::RND_W-1:0]  rnd_res;
    logic signed [ifcf_pkg::SUM_W-1:0]  sum_main;
    logic signed [ifcf_pkg::ACC_W-1:0]  acc_new;
    logic signed [ifcf_pkg::VAL_W-1:0]  tok_val;

    always_comb begin
        // forwarded write wins, then never-written entries read as zero
        if (r_byp_hit) begin
            acc_old = r_byp_data;
        end else if (r_fresh) begin
            acc_old = '0;
        end else begin
            acc_old = r_rd;
        end
        p_main   = r_s1.factor * r_s1.value;
        p_res    = r_s1.resid * r_s1.value;
        rnd_main = ifcf_pkg::round_q16(p_main);
        rnd_res  = ifcf_pkg::round_q16(p_res);
        sum_main = ifcf_pkg::SUM_W'(acc_old) + ifcf_pkg::SUM_W'(rnd_main);
        tok_val  = ifcf_pkg::sat_out(sum_main);
        // firing restarts the entry with the residual share
        acc_new  = r_s1.fire ? ifcf_pkg::sat_acc(ifcf_pkg::SUM_W'(rnd_res))
                             : ifcf_pkg::sat_acc(sum_main);
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_acc[r_s1.idx] <= acc_new;
        end
        if (s_accept) begin
            r_rd <= mem_acc[issue.idx];
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (s1_adv && (ifcf_pkg::FILL_W'(r_s1.idx) == r_fill)) begin
            n_fill = r_fill + 1'b1;
        end
        n_s1_valid = s_accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_valid);
        if (s1_adv && r_s1.fire) begin
            n_o_valid = 1'b1;
        end else if (i_m_tready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload
    logic signed [ifcf_pkg::VAL_W-1:0] r_o_value;
    logic                              r_o_last;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1       <= issue;
            r_byp_hit  <= s1_adv && (r_s1.idx == issue.idx);
            r_byp_data <= acc_new;
            r_fresh    <= ifcf_pkg::FILL_W'(issue.idx) >= r_fill;
        end
        if (s1_adv && r_s1.fire) begin
            r_o_value <= tok_val;
            r_o_last  <= r_s1.last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_value;
    assign o_m_tlast  = r_o_last;

`ifndef SYNTH
    // written entries always form a prefix, so no element points past it
    a_idx_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (ifcf_pkg::FILL_W'(r_s1.idx) <= r_fill))
        else $error("stage 1 index beyond accumulator fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ifcf_pkg::FILL_W'(ifcf_pkg::VECTOR_LEN))
        else $error("accumulator fill count overflow");

    // a firing element blocked by a full output must hold off the input
    a_fire_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.fire && r_o_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while firing element is stalled");

    // a pending token is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready) |=> (r_o_valid && $stable(r_o_value)))
        else $error("pending token lost");
`endif

endmodule
